// ----- design/ucs8_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ucs8_pkg: shared types and constants for the UTF-16/UTF-32 to UTF-8 block
// Item structs, command and status codes, register indexes, range limits
// and the UTF-8 length function.
// ----------------------------------------------------------------------------
package ucs8_pkg;

  localparam int FIFO_DEPTH_DEF = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 2;
  localparam int CODE_W         = 31;

  // input commands
  typedef enum logic [1:0] {
    FUNC_DATA    = 2'd0,
    FUNC_END     = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DATA       = 2'd0,
    ST_ILLEGAL    = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FMT_UCS2  = 2'd0,
    FMT_UTF16 = 2'd1,
    FMT_UTF32 = 2'd2,
    FMT_UCS4  = 2'd3
  } unit_format_t;

  typedef enum logic [1:0] {
    ORD_FIXED_BIG     = 2'd0,
    ORD_FIXED_LITTLE  = 2'd1,
    ORD_DETECT_BIG    = 2'd2,
    ORD_DETECT_LITTLE = 2'd3
  } order_mode_t;

  typedef enum logic [1:0] {
    JOB_CHAR       = 2'd0,
    JOB_ILLEGAL    = 2'd1,
    JOB_INCOMPLETE = 2'd2
  } job_kind_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE  = 2'd1;

  // code point limits
  localparam logic [31:0] BOM_BE_WORD  = 32'h0000_feff;
  localparam logic [31:0] BOM_LE_WORD  = 32'hfffe_0000;
  localparam logic [31:0] BOM_LE_HALF  = 32'h0000_fffe;
  localparam logic [31:0] NONCHAR_FE   = 32'h0000_fffe;
  localparam logic [31:0] NONCHAR_FF   = 32'h0000_ffff;
  localparam logic [31:0] SURR_MIN     = 32'h0000_d800;
  localparam logic [31:0] SURR_HI_MAX  = 32'h0000_dbff;
  localparam logic [31:0] SURR_LO_MIN  = 32'h0000_dc00;
  localparam logic [31:0] SURR_MAX     = 32'h0000_dfff;
  localparam logic [31:0] UTF32_MAX    = 32'h0010_ffff;
  localparam logic [31:0] UCS4_MAX     = 32'h7fff_ffff;
  localparam logic [20:0] SUPP_BASE    = 21'h01_0000;

  typedef struct packed {
    func_t      func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    status_t    status;
  } out_item_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [CODE_W-1:0] code;
  } job_t;

  // number of UTF-8 bytes minus one
  function automatic logic [2:0] utf8_rem(input logic [CODE_W-1:0] code);
    logic [2:0] r;
    if (code <= 31'h0000_007f)      r = 3'd0;
    else if (code <= 31'h0000_07ff) r = 3'd1;
    else if (code <= 31'h0000_ffff) r = 3'd2;
    else if (code <= 31'h001f_ffff) r = 3'd3;
    else if (code <= 31'h03ff_ffff) r = 3'd4;
    else                            r = 3'd5;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/ucs8_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ucs8_front: unit assembly and classification
// Gathers bytes into units, handles the byte order mark, pairs surrogates,
// checks ranges and pushes one job per character or error.
// ----------------------------------------------------------------------------
module ucs8_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           take,
  input  wire ucs8_pkg::in_item_t             item,
  input  wire logic                           cfg_we,
  input  wire logic [ucs8_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ucs8_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                                job_push,
  output ucs8_pkg::job_t                      job
);
  import ucs8_pkg::*;

  unit_format_t fmt_r,    fmt_nxt;
  order_mode_t  mode_r,   mode_nxt;
  logic [23:0]  shift_r,  shift_nxt;
  logic [1:0]   count_r,  count_nxt;
  logic [9:0]   hs_r,     hs_nxt;
  logic         pend_r,   pend_nxt;
  logic         little_r, little_nxt;
  logic         bomd_r,   bomd_nxt;

  logic        wide;
  logic [2:0]  need;
  logic [31:0] shifted, raw, swapped, u;
  logic        is_bom_be, is_bom_le;
  logic        nonchar, in_surr, in_low, in_high;
  logic [20:0] paired;

  always_comb begin
    wide      = fmt_r[1];
    need      = wide ? 3'd4 : 3'd2;
    shifted   = {shift_r, item.data_byte};
    raw       = wide ? shifted : {16'h0000, shifted[15:0]};
    swapped   = wide ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]}
                     : {16'h0000, raw[7:0], raw[15:8]};
    u         = little_r ? swapped : raw;
    is_bom_be = (raw == BOM_BE_WORD);
    is_bom_le = wide ? (raw == BOM_LE_WORD) : (raw == BOM_LE_HALF);
    nonchar   = (u == NONCHAR_FE) || (u == NONCHAR_FF);
    in_surr   = u inside {[SURR_MIN:SURR_MAX]};
    in_low    = u inside {[SURR_LO_MIN:SURR_MAX]};
    in_high   = u inside {[SURR_MIN:SURR_HI_MAX]};
    paired    = {1'b0, hs_r, u[9:0]} + SUPP_BASE;
  end

  always_comb begin
    fmt_nxt    = fmt_r;
    mode_nxt   = mode_r;
    shift_nxt  = shift_r;
    count_nxt  = count_r;
    hs_nxt     = hs_r;
    pend_nxt   = pend_r;
    little_nxt = little_r;
    bomd_nxt   = bomd_r;
    job_push   = 1'b0;
    job        = '{kind: JOB_CHAR, code: '0};

    if (take) begin
      case (item.func)
        FUNC_END: begin
          if (count_r != 2'd0 || pend_r) begin
            job_push  = 1'b1;
            job.kind  = JOB_INCOMPLETE;
            shift_nxt = '0;
            count_nxt = '0;
            hs_nxt    = '0;
            pend_nxt  = 1'b0;
          end
        end
        FUNC_RESTART: begin
          shift_nxt  = '0;
          count_nxt  = '0;
          hs_nxt     = '0;
          pend_nxt   = 1'b0;
          little_nxt = mode_r[0];
          bomd_nxt   = ~mode_r[1];
        end
        FUNC_DATA: begin
          if (({1'b0, count_r} + 3'd1) < need) begin
            count_nxt = count_r + 2'd1;
            shift_nxt = shifted[23:0];
          end else begin
            shift_nxt = '0;
            count_nxt = '0;
            if (!bomd_r && (is_bom_be || is_bom_le)) begin
              // mark consumed, sets the order
              bomd_nxt   = 1'b1;
              little_nxt = is_bom_le;
            end else begin
              bomd_nxt = 1'b1;
              job.code = u[CODE_W-1:0];
              case (fmt_r)
                FMT_UCS2: begin
                  job_push = 1'b1;
                  if (nonchar || in_surr) job.kind = JOB_ILLEGAL;
                end
                FMT_UTF16: begin
                  if (pend_r) begin
                    job_push = 1'b1;
                    hs_nxt   = '0;
                    pend_nxt = 1'b0;
                    if (!in_low) job.kind = JOB_ILLEGAL;
                    else         job.code = {10'h000, paired};
                  end else if (in_low || nonchar) begin
                    job_push = 1'b1;
                    job.kind = JOB_ILLEGAL;
                  end else if (in_high) begin
                    hs_nxt   = u[9:0];
                    pend_nxt = 1'b1;
                  end else begin
                    job_push = 1'b1;
                  end
                end
                FMT_UTF32: begin
                  job_push = 1'b1;
                  if (nonchar || in_surr || u > UTF32_MAX) job.kind = JOB_ILLEGAL;
                end
                default: begin
                  job_push = 1'b1;
                  if (nonchar || in_surr || u > UCS4_MAX) job.kind = JOB_ILLEGAL;
                end
              endcase
              if (job.kind == JOB_ILLEGAL) job.code = '0;
            end
          end
        end
        default: ;
      endcase
    end

    if (cfg_we) begin
      case (cfg_index)
        REG_UNIT_FORMAT: begin
          fmt_nxt   = unit_format_t'(cfg_data);
          shift_nxt = '0;
          count_nxt = '0;
          hs_nxt    = '0;
          pend_nxt  = 1'b0;
        end
        REG_ORDER_MODE: begin
          mode_nxt   = order_mode_t'(cfg_data);
          little_nxt = cfg_data[0];
          bomd_nxt   = ~cfg_data[1];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_UTF16;
      mode_r   <= ORD_DETECT_BIG;
      shift_r  <= '0;
      count_r  <= '0;
      hs_r     <= '0;
      pend_r   <= 1'b0;
      little_r <= 1'b0;
      bomd_r   <= 1'b0;
    end else begin
      fmt_r    <= fmt_nxt;
      mode_r   <= mode_nxt;
      shift_r  <= shift_nxt;
      count_r  <= count_nxt;
      hs_r     <= hs_nxt;
      pend_r   <= pend_nxt;
      little_r <= little_nxt;
      bomd_r   <= bomd_nxt;
    end
  end

  // a pending high surrogate only exists in UTF-16 mode
  a_pend_utf16: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (fmt_r == FMT_UTF16))
    else $error("surrogate pending outside UTF-16");

  // a narrow unit never holds more than one byte between transfers
  a_narrow_count: assert property (@(posedge clk) disable iff (!rst_n)
    !fmt_r[1] |-> (count_r <= 2'd1))
    else $error("narrow unit byte count overflow");

endmodule
`default_nettype wire

// ----- design/ucs8_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ucs8_fifo: job queue between front and back
// Small register queue; the front stalls on full, the back on empty.
// ----------------------------------------------------------------------------
module ucs8_fifo #(
  parameter int DEPTH = ucs8_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ucs8_pkg::job_t wdata,
  input  wire logic           pop,
  output ucs8_pkg::job_t      rdata,
  output logic                empty,
  output logic                full
);
  import ucs8_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r,    cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign rdata = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wdata;
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("job queue read while empty");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("job queue count did not advance on write");

endmodule
`default_nettype wire

// ----- design/ucs8_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ucs8_back: UTF-8 byte sequencer
// Takes one job at a time, emits its bytes lead first into an output
// register that the result side drains.
// ----------------------------------------------------------------------------
module ucs8_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ucs8_pkg::job_t job,
  input  wire logic           job_valid,
  output logic                job_pop,
  output ucs8_pkg::out_item_t out_item,
  output logic                out_empty,
  input  wire logic           out_pop
);
  import ucs8_pkg::*;

  logic              cur_valid_r, cur_valid_nxt;
  job_kind_t         cur_kind_r,  cur_kind_nxt;
  logic [CODE_W-1:0] cur_code_r,  cur_code_nxt;
  logic [2:0]        cur_len_r,   cur_len_nxt;
  logic [2:0]        cur_rem_r,   cur_rem_nxt;
  logic              cur_first_r, cur_first_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r,  out_item_nxt;

  logic              emit, done_cur;
  logic [CODE_W-1:0] chunk;
  out_item_t         built;

  assign out_empty = ~out_valid_r;
  assign out_item  = out_item_r;
  assign emit      = cur_valid_r && (!out_valid_r || out_pop);
  assign done_cur  = emit && (cur_rem_r == 3'd0);
  assign job_pop   = job_valid && (!cur_valid_r || done_cur);

  always_comb begin
    case (cur_rem_r)
      3'd0:    chunk = cur_code_r;
      3'd1:    chunk = cur_code_r >> 6;
      3'd2:    chunk = cur_code_r >> 12;
      3'd3:    chunk = cur_code_r >> 18;
      3'd4:    chunk = cur_code_r >> 24;
      default: chunk = cur_code_r >> 30;
    endcase

    built.last = (cur_rem_r == 3'd0);
    case (cur_kind_r)
      JOB_ILLEGAL:    built.status = ST_ILLEGAL;
      JOB_INCOMPLETE: built.status = ST_INCOMPLETE;
      default:        built.status = ST_DATA;
    endcase
    if (cur_kind_r != JOB_CHAR) begin
      built.out_byte = 8'h00;
    end else if (cur_first_r) begin
      case (cur_len_r)
        3'd0:    built.out_byte = {1'b0, chunk[6:0]};
        3'd1:    built.out_byte = {3'b110, chunk[4:0]};
        3'd2:    built.out_byte = {4'b1110, chunk[3:0]};
        3'd3:    built.out_byte = {5'b11110, chunk[2:0]};
        3'd4:    built.out_byte = {6'b111110, chunk[1:0]};
        default: built.out_byte = {7'b1111110, chunk[0]};
      endcase
    end else begin
      built.out_byte = {2'b10, chunk[5:0]};
    end
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_kind_nxt  = cur_kind_r;
    cur_code_nxt  = cur_code_r;
    cur_len_nxt   = cur_len_r;
    cur_rem_nxt   = cur_rem_r;
    cur_first_nxt = cur_first_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;

    if (job_pop) begin
      cur_valid_nxt = 1'b1;
      cur_kind_nxt  = job.kind;
      cur_code_nxt  = job.code;
      cur_len_nxt   = (job.kind == JOB_CHAR) ? utf8_rem(job.code) : 3'd0;
      cur_rem_nxt   = (job.kind == JOB_CHAR) ? utf8_rem(job.code) : 3'd0;
      cur_first_nxt = 1'b1;
    end else if (done_cur) begin
      cur_valid_nxt = 1'b0;
    end else if (emit) begin
      cur_rem_nxt   = cur_rem_r - 3'd1;
      cur_first_nxt = 1'b0;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = built;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_kind_r  <= cur_kind_nxt;
    cur_code_r  <= cur_code_nxt;
    cur_len_r   <= cur_len_nxt;
    cur_rem_r   <= cur_rem_nxt;
    cur_first_r <= cur_first_nxt;
    out_item_r  <= out_item_nxt;
  end

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && cur_kind_r != JOB_CHAR) |-> (cur_rem_r == 3'd0))
    else $error("error job spans more than one result");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.status != ST_DATA) |->
      (out_item_r.out_byte == 8'h00 && out_item_r.last))
    else $error("error result carries data");

endmodule
`default_nettype wire

// ----- design/ucs_utf16_utf32_to_utf8.sv -----
// A result reaches the out_ ports after the transfer of the byte that
//   completes its unit, through job queue write, sequencer load and output reg.
// Throughput: one input byte per cycle while the job queue has room; the
//   result side moves one UTF-8 byte per cycle while out_pop drains it, so a
//   character's 1 to 6 bytes in the output sequencer set the sustained intake.
// Reset (rst_n low, synchronous): registers to defaults, queue and outputs empty.
`default_nettype none
// ----------------------------------------------------------------------------
// ucs_utf16_utf32_to_utf8: UCS-2/UTF-16/UTF-32/UCS-4 to UTF-8 transcoder
// Byte stream in, UTF-8 bytes out, with byte order detection, surrogate
// pairing, range checks and error results.
// ----------------------------------------------------------------------------
module ucs_utf16_utf32_to_utf8 #(
  parameter int FIFO_DEPTH = ucs8_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input queue side
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire ucs8_pkg::in_item_t              in_item,
  // result queue side
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output ucs8_pkg::out_item_t                  out_item,
  // register writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ucs8_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ucs8_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ucs8_pkg::*;

  logic in_take;
  logic job_push;
  job_t job_wr;
  job_t job_rd;
  logic job_empty;
  logic job_pop;

  // Registers are always writable; writes are expected only while idle.
  assign cfg_ready = 1'b1;

  // The front takes a byte whenever the job queue can hold one more job,
  // since any byte may complete a unit.
  assign in_take = in_push && !in_full;

  // Front: assembles units, consumes the BOM, pairs surrogates and decides
  // between a character job, an illegal-sequence job, an incomplete-unit job or nothing.
  ucs8_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_take),
    .item      (in_item),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_push  (job_push),
    .job       (job_wr)
  );

  // Job queue decouples intake from the byte sequencer.
  ucs8_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_wr),
    .pop   (job_pop),
    .rdata (job_rd),
    .empty (job_empty),
    .full  (in_full)
  );

  // Back: one UTF-8 byte per cycle into the output register while the result side
  // drains it, next job loaded in the same cycle as the last byte of the current one.
  ucs8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_rd),
    .job_valid (!job_empty),
    .job_pop   (job_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule
`default_nettype wire

// ----- test/tb_ucs_utf16_utf32_to_utf8.sv -----
// ----------------------------------------------------------------------------
// tb_ucs_utf16_utf32_to_utf8: self-checking bench for the UTF-8 transcoder
// Feeds byte streams in every unit format and byte order setting, predicts
// the UTF-8 bytes and error results in the bench, and compares each popped
// result against the oldest prediction. Both queue sides idle at random.
// ----------------------------------------------------------------------------
module tb_ucs_utf16_utf32_to_utf8;
  import ucs8_pkg::*;

  localparam int TAIL_CYCLES = 8;       // wait after the last predicted result, in clock cycles
  localparam int LIMIT       = 200000;  // run watchdog, in clock cycles

  // register indexes past order_mode; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  in_item_t              in_item;
  logic                  out_empty;
  logic                  out_pop;
  out_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ucs_utf16_utf32_to_utf8 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predicted transcoder state. Updated at every accepted input transfer and
  // every register write, in the order the block sees them.
  // --------------------------------------------------------------------------
  unit_format_t cur_format;
  order_mode_t  cur_order;
  logic [31:0]  unit_bytes;   // bytes of the unit so far, first byte on top
  logic [1:0]   unit_count;
  logic [9:0]   hi_bits;      // payload of a waiting high surrogate
  logic         hi_pending;
  logic         little_end;
  logic         bom_seen;

  out_item_t    utf8_expect[$];   // predicted results, oldest first

  int  fail_count  = 0;
  int  items_sent  = 0;   // accepted items that the block acts on
  int  hold_cycles = 0;   // receiver hold-off request, drained by the receiver
  bit  no_gaps     = 0;   // both sides run back to back while set

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  task automatic clear_partial();
    unit_bytes = '0;
    unit_count = '0;
    hi_bits    = '0;
    hi_pending = 1'b0;
  endtask

  // detect modes start undecided with the mode's default order
  task automatic load_order();
    little_end = cur_order[0];
    bom_seen   = !cur_order[1];
  endtask

  task automatic push_result(input logic [7:0] b, input logic lst, input status_t st);
    utf8_expect.push_back('{out_byte: b, last: lst, status: st});
  endtask

  // error result drops the partial unit and any waiting high surrogate
  task automatic flag_error(input status_t st);
    clear_partial();
    push_result(8'h00, 1'b1, st);
  endtask

  task automatic emit_utf8(input logic [31:0] c);
    int         n;
    logic [7:0] lead;
    if (c <= 32'h7f) begin
      push_result(c[7:0], 1'b1, ST_DATA);
    end else begin
      if (c <= 32'h7ff) begin
        n = 2; lead = 8'hc0 | c[10:6];
      end else if (c <= 32'hffff) begin
        n = 3; lead = 8'he0 | c[15:12];
      end else if (c <= 32'h1f_ffff) begin
        n = 4; lead = 8'hf0 | c[20:18];
      end else if (c <= 32'h3ff_ffff) begin
        n = 5; lead = 8'hf8 | c[25:24];
      end else begin
        n = 6; lead = 8'hfc | c[30];
      end
      push_result(lead, 1'b0, ST_DATA);
      for (int i = 1; i < n; i++)
        push_result(8'h80 | 8'((c >> (6 * (n - 1 - i))) & 32'h3f), i == n - 1, ST_DATA);
    end
  endtask

  // one complete unit: BOM check, byte swap, range check, surrogate join
  task automatic finish_unit(input logic [31:0] raw, input logic wide);
    logic [31:0] u;
    logic        bad;
    if (!bom_seen) begin
      bom_seen = 1'b1;
      if ((!wide && raw == 32'h0000_feff) || (wide && raw == BOM_BE_WORD)) begin
        little_end = 1'b0;
        return;
      end
      if ((!wide && raw == BOM_LE_HALF) || (wide && raw == BOM_LE_WORD)) begin
        little_end = 1'b1;
        return;
      end
    end
    if (!little_end)
      u = raw;
    else if (wide)
      u = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
    else
      u = {16'h0, raw[7:0], raw[15:8]};

    bad = 1'b0;
    case (cur_format)
      FMT_UCS2: begin
        bad = (u >= NONCHAR_FE) || (u >= SURR_MIN && u <= SURR_MAX);
      end
      FMT_UTF16: begin
        if (hi_pending) begin
          bad = (u < SURR_LO_MIN) || (u > SURR_MAX);
          if (!bad) begin
            u = 32'h1_0000 + {12'h0, hi_bits, u[9:0]};
            hi_pending = 1'b0;
            hi_bits    = '0;
          end
        end else begin
          bad = (u >= SURR_LO_MIN && u <= SURR_MAX) || (u >= NONCHAR_FE);
          if (!bad && u >= SURR_MIN && u <= SURR_HI_MAX) begin
            hi_bits    = u[9:0];
            hi_pending = 1'b1;
            return;
          end
        end
      end
      FMT_UTF32: begin
        bad = (u == NONCHAR_FE) || (u == NONCHAR_FF) || (u > UTF32_MAX) ||
              (u >= SURR_MIN && u <= SURR_MAX);
      end
      default: begin
        bad = (u == NONCHAR_FE) || (u == NONCHAR_FF) || (u > UCS4_MAX) ||
              (u >= SURR_MIN && u <= SURR_MAX);
      end
    endcase
    if (bad)
      flag_error(ST_ILLEGAL);
    else
      emit_utf8(u);
  endtask

  task automatic transcode_item(input func_t f, input logic [7:0] b);
    logic        wide;
    int          need;
    logic [31:0] raw;
    wide = cur_format[1];
    need = wide ? 4 : 2;
    case (f)
      FUNC_END: begin
        if (unit_count != 0 || hi_pending)
          flag_error(ST_INCOMPLETE);
      end
      FUNC_RESTART: begin
        clear_partial();
        load_order();
      end
      FUNC_DATA: begin
        unit_bytes = {unit_bytes[23:0], b};
        if (int'(unit_count) + 1 < need) begin
          unit_count = unit_count + 2'd1;
        end else begin
          raw = wide ? unit_bytes : {16'h0, unit_bytes[15:0]};
          unit_bytes = '0;
          unit_count = '0;
          finish_unit(raw, wide);
        end
      end
      default: ;  // unused command, no effect
    endcase
  endtask

  task automatic model_reset();
    cur_format = FMT_UTF16;
    cur_order  = ORD_DETECT_BIG;
    clear_partial();
    load_order();
  endtask

  task automatic model_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
    if (idx == REG_UNIT_FORMAT) begin
      cur_format = unit_format_t'(val);
      clear_partial();
    end else if (idx == REG_ORDER_MODE) begin
      cur_order = order_mode_t'(val);
      load_order();  // partial unit survives an order change
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: pops with random per-transfer waits, honors hold-off
  // requests, and checks each popped result against the oldest prediction.
  // Outputs are sampled right at the edge, so they hold pre-edge values.
  // --------------------------------------------------------------------------
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (utf8_expect.size() == 0) begin
      $error("unexpected result: out_byte %h last %b status %0d",
             got.out_byte, got.last, got.status);
      fail_count++;
    end else begin
      want = utf8_expect.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
        fail_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %b, got %b", want.last, got.last);
        fail_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fail_count++;
      end
    end
  endtask

  initial begin
    int pop_wait;
    out_pop <= 1'b0;
    pop_wait = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        check_result(out_item);
        pop_wait = no_gaps ? 0 : $urandom_range(0, 3);
      end
      // exactly one assignment to out_pop per edge
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_pop <= 1'b0;
      end else if (pop_wait > 0) begin
        pop_wait--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side helpers
  // --------------------------------------------------------------------------

  // One input transfer. Returns in the time step of the accepting edge, with
  // push still high, so a back-to-back item needs no second assignment there.
  task automatic send_item(input func_t f, input logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= '{func: f, data_byte: b};
    do @(posedge clk); while (in_full);
    transcode_item(f, b);
    if (f != FUNC_NONE)
      items_sent++;
  endtask

  // unit exactly as it appears in the stream, first byte on top
  task automatic send_raw(input logic [31:0] raw);
    if (cur_format[1]) begin
      send_item(FUNC_DATA, raw[31:24]);
      send_item(FUNC_DATA, raw[23:16]);
    end
    send_item(FUNC_DATA, raw[15:8]);
    send_item(FUNC_DATA, raw[7:0]);
  endtask

  // unit value, laid out in the byte order the block currently uses
  task automatic send_unit(input logic [31:0] u);
    if (!little_end)
      send_raw(u);
    else if (cur_format[1])
      send_raw({u[7:0], u[15:8], u[23:16], u[31:24]});
    else
      send_raw({16'h0, u[7:0], u[15:8]});
  endtask

  task automatic send_char(input logic [31:0] c);
    if (cur_format == FMT_UTF16 && c > 32'hffff) begin
      send_unit(SURR_MIN + ((c - 32'h1_0000) >> 10));
      send_unit(SURR_LO_MIN + ((c - 32'h1_0000) & 32'h3ff));
    end else begin
      send_unit(c);
    end
  endtask

  // legal code point of the current format, spread over all UTF-8 lengths
  function automatic logic [31:0] pick_char();
    int top;
    case (cur_format)
      FMT_UCS2: top = 2;
      FMT_UCS4: top = 5;
      default:  top = 3;
    endcase
    case ($urandom_range(0, top))
      0: return $urandom_range(0, 32'h7f);
      1: return $urandom_range(32'h80, 32'h7ff);
      2: return $urandom_range(0, 1) ? $urandom_range(32'h800, 32'hd7ff)
                                     : $urandom_range(32'he000, 32'hfffd);
      3: return (cur_format == FMT_UCS4) ? $urandom_range(32'h1_0000, 32'h1f_ffff)
                                         : $urandom_range(32'h1_0000, UTF32_MAX);
      4: return $urandom_range(32'h20_0000, 32'h3ff_ffff);
      default: return $urandom_range(32'h400_0000, UCS4_MAX);
    endcase
  endfunction

  task automatic send_illegal();
    int kind;
    kind = $urandom_range(0, 2);
    if (kind == 0) begin
      send_unit($urandom_range(0, 1) ? NONCHAR_FE : NONCHAR_FF);
    end else if (kind == 1) begin
      // lone low surrogate (any surrogate for UCS-2 and the wide formats)
      send_unit(cur_format == FMT_UTF16 ? $urandom_range(SURR_LO_MIN, SURR_MAX)
                                        : $urandom_range(SURR_MIN, SURR_MAX));
    end else if (cur_format == FMT_UTF16) begin
      // high surrogate followed by something other than a low one
      send_unit($urandom_range(SURR_MIN, SURR_HI_MAX));
      send_unit($urandom_range(0, 32'hd7ff));
    end else if (cur_format == FMT_UTF32) begin
      send_unit($urandom_range(UTF32_MAX + 1, 32'hffff_ffff));
    end else if (cur_format == FMT_UCS4) begin
      send_unit(32'h8000_0000 | $urandom());
    end else begin
      send_unit($urandom_range(SURR_MIN, SURR_MAX));
    end
  endtask

  // Waits until every predicted result has come out, then lets the block
  // finish any unit that produces nothing.
  task automatic settle();
    in_push <= 1'b0;
    while (utf8_expect.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_config(idx, val);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: UTF-16 with big-endian default and BOM detection.
  task automatic test_utf16_cases();
    send_raw(BOM_BE_WORD);                       // BOM, consumed, sets big
    send_raw(32'h0000);                          // smallest character
    send_raw(32'h20ac);                          // three-byte character
    send_raw(32'hdbff); send_raw(32'hdfff);      // pair for U+10FFFF
    send_raw(32'hdc00);                          // lone low surrogate
    send_raw(32'hd800); send_raw(32'h0041);      // high without partner
    send_item(FUNC_DATA, 8'h12);                 // half a unit ...
    send_item(FUNC_END, 8'h00);                  // ... then end: incomplete
    send_raw(32'hd83d);                          // high surrogate waiting ...
    send_item(FUNC_END, 8'hff);                  // ... then end: incomplete
    send_item(FUNC_END, 8'hff);                  // nothing pending, no result
    send_item(FUNC_NONE, 8'h5a);                 // ignored command
    send_item(FUNC_RESTART, 8'h00);              // detection starts over
    send_raw(BOM_LE_HALF);                       // little-endian BOM
    send_raw(32'he900);                          // U+00E9 in little order
  endtask

  // UCS-4 in fixed big order: six-byte extremes, range limit, BOM as text.
  task automatic test_ucs4_cases();
    write_reg(REG_ORDER_MODE, ORD_FIXED_BIG);
    write_reg(REG_UNIT_FORMAT, FMT_UCS4);
    send_raw(UCS4_MAX);                          // largest code, six bytes
    send_raw(32'h8000_0000);                     // just past the range
    send_raw(BOM_BE_WORD);                       // plain U+FEFF here
    // writes past the last register change nothing
    write_reg(REG_SPARE_2, 2'($urandom_range(0, 3)));
    write_reg(REG_SPARE_3, 2'($urandom_range(0, 3)));
    send_raw(32'h0400_0000);                     // smallest six-byte code
  endtask

  // Receiver holds off while the sender keeps pushing, so the block backs
  // up and stalls its input.
  task automatic test_input_stall();
    write_reg(REG_UNIT_FORMAT, FMT_UTF16);
    hold_cycles = 150;
    repeat (16) send_char(pick_char());
  endtask

  // Random traffic across all register settings. Mostly legal characters,
  // with noise bytes, illegal units, ends, restarts and fresh BOMs mixed in.
  task automatic test_random_settings();
    int          base;
    int          pick;
    unit_format_t fmt;
    order_mode_t  ord;
    for (int p = 0; p < 8; p++) begin
      // first four phases sweep every value of both registers
      fmt = unit_format_t'(p < 4 ? p : $urandom_range(0, 3));
      ord = order_mode_t'(p < 4 ? 3 - p : $urandom_range(0, 3));
      write_reg(REG_ORDER_MODE, ord);
      write_reg(REG_UNIT_FORMAT, fmt);
      no_gaps = (p == 5);
      base = items_sent;
      while (items_sent - base < 25) begin
        pick = $urandom_range(0, 99);
        if (pick < 66) begin
          send_char(pick_char());
        end else if (pick < 72) begin
          send_item(FUNC_DATA, 8'($urandom_range(0, 255)));
        end else if (pick < 80) begin
          send_illegal();
        end else if (pick < 84) begin
          send_item(FUNC_END, 8'($urandom_range(0, 255)));
        end else if (pick < 90) begin
          send_item(FUNC_RESTART, 8'($urandom_range(0, 255)));
          if (cur_order[1] && $urandom_range(0, 1)) begin
            if (cur_format[1])
              send_raw($urandom_range(0, 1) ? BOM_BE_WORD : BOM_LE_WORD);
            else
              send_raw($urandom_range(0, 1) ? BOM_BE_WORD : BOM_LE_HALF);
          end
        end else if (pick < 93) begin
          send_item(FUNC_NONE, 8'($urandom_range(0, 255)));
        end else begin
          send_item(FUNC_DATA, 8'($urandom_range(0, 255)));
          send_item(FUNC_END, 8'($urandom_range(0, 255)));
        end
      end
      no_gaps = 0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n     <= 1'b0;
    in_push   <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    model_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_utf16_cases();
    test_ucs4_cases();
    test_input_stall();
    test_random_settings();

    settle();
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
